// ----- hdl/hpe_pkg.sv -----
package hpe_pkg;

	localparam int X_W     = 18;
	localparam int ORD_W   = 4;
	localparam int ACC_W   = 64;
	localparam int X2_W    = 35;
	localparam int COEF_W  = 14;
	localparam int HALF_W  = 32;
	localparam int N_ROWS  = 16;
	localparam int N_COLS  = 6;
	localparam int S_DATA_W = 24;
	localparam int M_USER_W = 2;

	typedef logic signed [COEF_W-1:0] coef_t;

	// one item as it moves down the chain
	typedef struct packed {
		logic                    valid;
		logic                    invalid;
		logic                    sat;
		logic [ORD_W-1:0]        order;
		logic signed [X_W-1:0]   x;
		logic [X2_W-1:0]         x2;
		logic signed [ACC_W-1:0] acc;
	} lane_t;

	// coefficients of the powers of x^2, highest power first
	localparam coef_t HERM_COEF [N_ROWS][N_COLS] = '{
		'{14'sd1, 14'sd0,   14'sd0,   14'sd0,     14'sd0,    14'sd0},
		'{14'sd1, 14'sd0,   14'sd0,   14'sd0,     14'sd0,    14'sd0},
		'{14'sd1, -14'sd1,  14'sd0,   14'sd0,     14'sd0,    14'sd0},
		'{14'sd1, -14'sd3,  14'sd0,   14'sd0,     14'sd0,    14'sd0},
		'{14'sd1, -14'sd6,  14'sd3,   14'sd0,     14'sd0,    14'sd0},
		'{14'sd1, -14'sd10, 14'sd15,  14'sd0,     14'sd0,    14'sd0},
		'{14'sd1, -14'sd15, 14'sd45,  -14'sd15,   14'sd0,    14'sd0},
		'{14'sd1, -14'sd21, 14'sd105, -14'sd105,  14'sd0,    14'sd0},
		'{14'sd1, -14'sd28, 14'sd210, -14'sd420,  14'sd105,  14'sd0},
		'{14'sd1, -14'sd36, 14'sd378, -14'sd1260, 14'sd945,  14'sd0},
		'{14'sd1, -14'sd45, 14'sd630, -14'sd3150, 14'sd4725, -14'sd945},
		'{14'sd0, 14'sd0,   14'sd0,   14'sd0,     14'sd0,    14'sd0},
		'{14'sd0, 14'sd0,   14'sd0,   14'sd0,     14'sd0,    14'sd0},
		'{14'sd0, 14'sd0,   14'sd0,   14'sd0,     14'sd0,    14'sd0},
		'{14'sd0, 14'sd0,   14'sd0,   14'sd0,     14'sd0,    14'sd0},
		'{14'sd0, 14'sd0,   14'sd0,   14'sd0,     14'sd0,    14'sd0}
	};

endpackage

// ----- hdl/hpe_mul_pipe.sv -----
module hpe_mul_pipe #(
	parameter int SHIFT = 26,
	parameter bit USE_X = 1'b0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          ce,
	input  logic          active,
	input  hpe_pkg::lane_t lane_in,
	output hpe_pkg::lane_t lane_out
);
	import hpe_pkg::*;

	localparam int MB_W   = X2_W;
	localparam int PROD_W = HALF_W + MB_W;
	localparam int SUM_W  = ACC_W + MB_W + 1;
	localparam logic [SUM_W-1:0] HALF    = SUM_W'(1) << (SHIFT - 1);
	localparam logic [SUM_W-1:0] LIM_POS = (SUM_W'(1) << (ACC_W - 1)) - SUM_W'(1);
	localparam logic [SUM_W-1:0] LIM_NEG = SUM_W'(1) << (ACC_W - 1);

	lane_t lane_s1, lane_s2, lane_s3, lane_s4, lane_s5;
	lane_t lane_nx;
	logic  act_s1, act_s2, act_s3, act_s4;

	logic [ACC_W-1:0]  ma_s1;
	logic [MB_W-1:0]   mb_s1;
	logic              neg_s1, neg_s2, neg_s3, neg_s4;
	logic [PROD_W-1:0] pl_s2, ph_s2;
	logic [SUM_W-1:0]  sum_s3;
	logic [ACC_W-1:0]  mag_s4;
	logic              over_s4;

	logic [ACC_W-1:0] a_mag;
	logic [X_W-1:0]   x_mag;
	logic [MB_W-1:0]  b_mag;
	logic             b_neg;
	logic [SUM_W-1:0] q, lim;
	logic             over;
	logic [ACC_W-1:0] mag_res;

	always_comb begin
		a_mag = lane_in.acc[ACC_W-1] ? (~lane_in.acc + ACC_W'(1)) : lane_in.acc;
		x_mag = lane_in.x[X_W-1] ? (~lane_in.x + X_W'(1)) : lane_in.x;
		if (USE_X) begin
			b_mag = MB_W'(x_mag);
			b_neg = lane_in.x[X_W-1];
		end else begin
			b_mag = lane_in.x2;
			b_neg = 1'b0;
		end
	end

	// rounded product is clipped to the magnitude the sign allows
	always_comb begin
		q       = sum_s3 >> SHIFT;
		lim     = neg_s3 ? LIM_NEG : LIM_POS;
		over    = q > lim;
		mag_res = over ? lim[ACC_W-1:0] : q[ACC_W-1:0];
	end

	always_comb begin
		lane_nx = lane_s4;
		if (act_s4) begin
			lane_nx.acc = neg_s4 ? (~mag_s4 + ACC_W'(1)) : mag_s4;
			lane_nx.sat = lane_s4.sat | over_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_s1 <= '0;
			lane_s2 <= '0;
			lane_s3 <= '0;
			lane_s4 <= '0;
			lane_s5 <= '0;
			act_s1  <= 1'b0;
			act_s2  <= 1'b0;
			act_s3  <= 1'b0;
			act_s4  <= 1'b0;
		end else if (ce) begin
			lane_s1 <= lane_in;
			act_s1  <= active;
			lane_s2 <= lane_s1;
			act_s2  <= act_s1;
			lane_s3 <= lane_s2;
			act_s3  <= act_s2;
			lane_s4 <= lane_s3;
			act_s4  <= act_s3;
			lane_s5 <= lane_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ma_s1   <= a_mag;
			mb_s1   <= b_mag;
			neg_s1  <= lane_in.acc[ACC_W-1] ^ b_neg;
			pl_s2   <= {{MB_W{1'b0}}, ma_s1[HALF_W-1:0]} * {{HALF_W{1'b0}}, mb_s1};
			ph_s2   <= {{MB_W{1'b0}}, ma_s1[ACC_W-1:HALF_W]} * {{HALF_W{1'b0}}, mb_s1};
			neg_s2  <= neg_s1;
			sum_s3  <= (SUM_W'(ph_s2) << HALF_W) + SUM_W'(pl_s2) + HALF;
			neg_s3  <= neg_s2;
			mag_s4  <= mag_res;
			over_s4 <= over;
			neg_s4  <= neg_s3;
		end
	end

	assign lane_out = lane_s5;

endmodule

// ----- hdl/hpe_horner_cell.sv -----
module hpe_horner_cell #(
	parameter int K         = 1,
	parameter int FRAC_BITS = 13
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           ce,
	input  hpe_pkg::lane_t lane_in,
	output hpe_pkg::lane_t lane_out
);
	import hpe_pkg::*;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	lane_t lane_m, lane_s6, lane_nx;
	logic  act_in, act_m;
	logic signed [ACC_W-1:0] c;
	logic [ACC_W:0]          s;
	logic                    ovf;

	// step k runs only for orders with more than k terms
	assign act_in = lane_in.valid && !lane_in.invalid &&
		(lane_in.order[ORD_W-1:1] >= (ORD_W-1)'(K));
	assign act_m = lane_m.valid && !lane_m.invalid &&
		(lane_m.order[ORD_W-1:1] >= (ORD_W-1)'(K));

	hpe_mul_pipe #(
		.SHIFT(2 * FRAC_BITS),
		.USE_X(1'b0)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.ce      (ce),
		.active  (act_in),
		.lane_in (lane_in),
		.lane_out(lane_m)
	);

	always_comb begin
		c   = ACC_W'(HERM_COEF[lane_m.order][K]) <<< FRAC_BITS;
		s   = {lane_m.acc[ACC_W-1], lane_m.acc} + {c[ACC_W-1], c};
		ovf = s[ACC_W] != s[ACC_W-1];
		lane_nx = lane_m;
		if (act_m) begin
			if (ovf) begin
				lane_nx.acc = s[ACC_W] ? ACC_MIN : ACC_MAX;
				lane_nx.sat = 1'b1;
			end else begin
				lane_nx.acc = s[ACC_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_s6 <= '0;
		end else if (ce) begin
			lane_s6 <= lane_nx;
		end
	end

	assign lane_out = lane_s6;

endmodule

// ----- hdl/hermite_polynomial_eval_core.sv -----
// Probabilists' Hermite polynomial He_n(x), orders 0 to MAX_ORDER.
// Input stream: s_axis_tdata carries x_value (signed, FRAC_BITS fraction bits)
// and poly_order. Output stream: m_axis_tdata is He_n(x) in signed 64-bit
// fixed point, m_axis_tuser carries order_invalid and saturated.
// Every input beat gives exactly one output beat, in order.
// The item runs down a row of Horner cells, one per power of x^2, each cell
// a multiply pipe (abs, split 32-bit partial products, round, clip, sign)
// plus a saturating coefficient add; odd orders pass one more multiply by x.
// Throughput: one beat per cycle while the receiver takes beats, set by the fully pipelined cell chain.
// An order above MAX_ORDER returns zero with order_invalid set.
// When the receiver stalls, the output register holds its beat and the whole
// chain freezes; s_axis_tready drops only while a held beat is not taken.
// Reset empties the chain and clears m_axis_tvalid; the data registers are not reset.
module hermite_polynomial_eval_core #(
	parameter int FRAC_BITS = 13,
	parameter int MAX_ORDER = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [hpe_pkg::S_DATA_W-1:0]  s_axis_tdata,  // x_value, poly_order
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [hpe_pkg::ACC_W-1:0]     m_axis_tdata,  // poly_value
	output logic [hpe_pkg::M_USER_W-1:0]  m_axis_tuser   // order_invalid, saturated
);
	import hpe_pkg::*;

	localparam int N_CELLS = MAX_ORDER / 2;

	logic ce;
	logic signed [X_W-1:0]     x_in;
	logic [ORD_W-1:0]          order_in;
	logic signed [2*X_W-1:0]   xx;

	lane_t lane_s0;
	lane_t chain [N_CELLS+1];
	lane_t lane_odd;
	logic  act_odd;

	logic                      m_valid_q;
	logic [ACC_W-1:0]          m_data_q;
	logic [M_USER_W-1:0]       m_user_q;

	assign ce            = !m_valid_q || m_axis_tready;
	assign s_axis_tready = ce;

	assign x_in     = s_axis_tdata[X_W-1:0];
	assign order_in = s_axis_tdata[X_W+ORD_W-1:X_W];
	assign xx       = x_in * x_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_s0 <= '0;
		end else if (ce) begin
			lane_s0.valid   <= s_axis_tvalid;
			lane_s0.invalid <= order_in > ORD_W'(MAX_ORDER);
			lane_s0.sat     <= 1'b0;
			lane_s0.order   <= order_in;
			lane_s0.x       <= x_in;
			lane_s0.x2      <= xx[X2_W-1:0];
			lane_s0.acc     <= ACC_W'(1) << FRAC_BITS;
		end
	end

	assign chain[0] = lane_s0;

	for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
		hpe_horner_cell #(
			.K        (g + 1),
			.FRAC_BITS(FRAC_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ce      (ce),
			.lane_in (chain[g]),
			.lane_out(chain[g+1])
		);
	end

	assign act_odd = chain[N_CELLS].valid && !chain[N_CELLS].invalid &&
		chain[N_CELLS].order[0];

	hpe_mul_pipe #(
		.SHIFT(FRAC_BITS),
		.USE_X(1'b1)
	) u_odd (
		.clk     (clk),
		.arst_n  (arst_n),
		.ce      (ce),
		.active  (act_odd),
		.lane_in (chain[N_CELLS]),
		.lane_out(lane_odd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ce) begin
			m_valid_q <= lane_odd.valid;
		end
	end

	// invalid orders leave the accumulator untouched, so mask it here
	always_ff @(posedge clk) begin
		if (ce) begin
			m_data_q <= lane_odd.invalid ? '0 : lane_odd.acc;
			m_user_q <= {lane_odd.sat & ~lane_odd.invalid, lane_odd.invalid};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule
